// ===== rtl/bsb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types and constants for the backend selector/balancer.
// ----------------------------------------------------------------------------
package bsb_pkg;

  localparam int NUM_BACKENDS_DEF = 16;

  typedef enum logic [2:0] {
    FN_SELECT  = 3'd0,
    FN_SUCCESS = 3'd1,
    FN_FAILURE = 3'd2,
    FN_HEALTH  = 3'd3,
    FN_ADD     = 3'd4,
    FN_REMOVE  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_RR = 2'd0,
    ST_LC = 2'd1,
    ST_WT = 2'd2
  } strat_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NONE    = 2'd1,
    STS_ABSENT  = 2'd2
  } status_t;

  // ram word: weight, active, total, failed, avg
  localparam int WORD_W = 8 + 16 + 32 + 32 + 20;

  typedef struct packed {
    logic [7:0]  weight;
    logic [15:0] active;
    logic [31:0] total;
    logic [31:0] failed;
    logic [19:0] avg;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD,
    S_UPD,
    S_OUT
  } state_t;

endpackage

// ===== rtl/bsb_ram.sv =====
// ----------------------------------------------------------------------------
// bsb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/backend_selector_balancer.sv =====
// ----------------------------------------------------------------------------
// backend_selector_balancer
// Backend table in one RAM; select scans slots one per cycle.
// ----------------------------------------------------------------------------
// Sequence: non-select events read the RAM, then modify/write it, then give
//   the result; select first scans one slot per cycle, then does the same
//   read and modify/write with a pick, or goes straight to the result without;
//   round robin adds the rr mod h reduction before the scan.
// Flow: one item at a time; in_ready returns the cycle after the result
//   is taken.
// Reset: synchronous active low; present/healthy flags, rr counter, strategy
//   (to least connections) and control state are cleared; the RAM is not.
module backend_selector_balancer
  import bsb_pkg::*;
#(
  parameter int NUM_BACKENDS = NUM_BACKENDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_strategy,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_slot,
  input  logic        in_healthy_flag,
  input  logic [7:0]  in_slot_weight,
  input  logic [19:0] in_response_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_chosen_valid,
  output logic [3:0]  out_chosen_slot,
  output logic [1:0]  out_status,
  output logic [15:0] out_active_count
);
  localparam int AW = $clog2(NUM_BACKENDS);
  localparam int CW = $clog2(NUM_BACKENDS + 1);

  state_t state_r, state_nxt;
  logic [1:0]  strat_r;
  logic [NUM_BACKENDS-1:0] present_r, healthy_r;
  logic [31:0] rr_r;

  // latched item
  logic [2:0]  func_r;
  logic [3:0]  slot_r;
  logic        flag_r;
  logic [7:0]  wt_r;
  logic [19:0] smp_r;

  // scan
  logic [CW-1:0] scan_r;     // address issued
  logic          rvld_r;     // data for scan_r-1 valid this cycle
  logic [AW-1:0] raddr_d_r;  // address of current rdata
  logic          best_v_r;
  logic [AW-1:0] best_r;
  logic [15:0]   best_act_r;
  logic [19:0]   best_avg_r;
  logic [8:0]    best_w_r;
  logic [CW-1:0] k_r;        // running index among eligible, compared with the rr target
  logic [CW-1:0] hcnt;

  // result register
  logic        ov_r;
  logic        o_cv_r;
  logic [3:0]  o_slot_r;
  logic [1:0]  o_sts_r;
  logic [15:0] o_act_r;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  bsb_ram #(.WIDTH(WORD_W), .DEPTH(NUM_BACKENDS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic [NUM_BACKENDS-1:0] elig;
  assign elig = present_r & healthy_r;

  always_comb begin
    hcnt = '0;
    for (int i = 0; i < NUM_BACKENDS; i++) begin
      hcnt = hcnt + CW'(elig[i]);
    end
  end

  logic accept;
  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign accept   = in_valid && in_ready;
  logic take;
  assign take = ov_r && out_ready;

  logic slot_ok;
  assign slot_ok = ({28'd0, slot_r} < 32'(NUM_BACKENDS));
  logic [AW-1:0] s_idx;
  assign s_idx = slot_r[AW-1:0];
  logic here;
  assign here = slot_ok && present_r[s_idx];

  // rr modulo by repeated subtraction would be long; instead keep rr target
  // computed by a small iterative reducer at scan start (see rem_r logic).
  logic [31:0] rem_r;
  logic        rem_busy_r;

  // scan compare for the slot in rdata
  logic [8:0]  cur_w;
  logic [28:0] lhs, rhs;
  logic        better;
  logic        cur_el;
  assign cur_w  = (ram_rdata.weight == 8'd0) ? 9'd1 : {1'b0, ram_rdata.weight};
  assign lhs    = 29'(ram_rdata.avg) * 29'(best_w_r);
  assign rhs    = 29'(best_avg_r) * 29'(cur_w);
  assign cur_el = rvld_r && elig[raddr_d_r];
  always_comb begin
    case (strat_t'(strat_r))
      ST_WT:   better = lhs < rhs;
      default: better = ram_rdata.active < best_act_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        state_nxt = (func_t'(in_func) == FN_SELECT) ? S_SCAN : S_RD;
      end
      S_SCAN: if (!rem_busy_r && !rvld_r && scan_r == CW'(NUM_BACKENDS)) begin
        state_nxt = best_v_r ? S_RD : S_OUT;
      end
      S_RD:  state_nxt = S_UPD;
      S_UPD: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ram address / write
  logic [AW-1:0] tgt;
  assign tgt = (func_t'(func_r) == FN_SELECT) ? best_r : s_idx;

  entry_t upd;
  logic [27:0] ewma;
  assign ewma = 28'(ram_rdata.avg) * 28'd179 + 28'(smp_r) * 28'd77;

  always_comb begin
    upd = ram_rdata;
    ram_we = 1'b0;
    case (func_t'(func_r))
      FN_SELECT: begin
        if (ram_rdata.active != 16'hFFFF) upd.active = ram_rdata.active + 16'd1;
        ram_we = 1'b1;
      end
      FN_SUCCESS, FN_FAILURE: begin
        if (ram_rdata.active != 16'd0) upd.active = ram_rdata.active - 16'd1;
        if (func_t'(func_r) == FN_SUCCESS) begin
          upd.total = ram_rdata.total + 32'd1;
          upd.avg   = (ram_rdata.avg == 20'd0) ? smp_r : ewma[27:8];
        end else begin
          upd.failed = ram_rdata.failed + 32'd1;
        end
        ram_we = here;
      end
      FN_ADD: begin
        upd = '{weight: wt_r, active: 16'd0, total: 32'd0, failed: 32'd0,
                avg: 20'd0};
        ram_we = slot_ok;
      end
      default: ram_we = 1'b0;
    endcase
    if (state_r != S_UPD) ram_we = 1'b0;
  end
  assign ram_waddr = tgt;
  assign ram_wdata = upd;
  assign ram_raddr = (state_r == S_SCAN) ? scan_r[AW-1:0] : tgt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      strat_r    <= ST_LC;
      present_r  <= '0;
      healthy_r  <= '0;
      rr_r       <= '0;
      ov_r       <= 1'b0;
      rvld_r     <= 1'b0;
      rem_busy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) strat_r <= cfg_strategy;
      if (take) ov_r <= 1'b0;

      if (accept) begin
        func_r  <= in_func;
        slot_r  <= in_slot;
        flag_r  <= in_healthy_flag;
        wt_r    <= in_slot_weight;
        smp_r   <= in_response_time;
        scan_r  <= '0;
        rvld_r  <= 1'b0;
        best_v_r <= 1'b0;
        best_r  <= '0;
        rem_r   <= rr_r;
        rem_busy_r <= (func_t'(in_func) == FN_SELECT) && (strat_r == ST_RR);
        k_r     <= '0;
      end

      if (state_r == S_SCAN) begin
        // rr: reduce rr_counter mod h, one conditional subtract of h<<j per cycle
        if (rem_busy_r) begin
          if (hcnt == '0) begin
            rem_busy_r <= 1'b0;
          end else if (rem_r >= 32'(hcnt) << 26) begin
            rem_r <= rem_r - (32'(hcnt) << 26);
          end else if (rem_r >= 32'(hcnt) << 20) begin
            rem_r <= rem_r - (32'(hcnt) << 20);
          end else if (rem_r >= 32'(hcnt) << 14) begin
            rem_r <= rem_r - (32'(hcnt) << 14);
          end else if (rem_r >= 32'(hcnt) << 8) begin
            rem_r <= rem_r - (32'(hcnt) << 8);
          end else if (rem_r >= 32'(hcnt) << 4) begin
            rem_r <= rem_r - (32'(hcnt) << 4);
          end else if (rem_r >= 32'(hcnt)) begin
            rem_r <= rem_r - 32'(hcnt);
          end else begin
            rem_busy_r <= 1'b0;
          end
        end else begin
          if (scan_r != CW'(NUM_BACKENDS)) begin
            scan_r <= scan_r + CW'(1);
            rvld_r <= 1'b1;
          end else begin
            rvld_r <= 1'b0;
          end
          raddr_d_r <= scan_r[AW-1:0];
          if (cur_el) begin
            if (strat_r == ST_RR) begin
              if ({{(32-CW){1'b0}}, k_r} == rem_r && !best_v_r) begin
                best_v_r <= 1'b1;
                best_r   <= raddr_d_r;
              end
              k_r <= k_r + CW'(1);
            end else if (!best_v_r || better) begin
              best_v_r   <= 1'b1;
              best_r     <= raddr_d_r;
              best_act_r <= ram_rdata.active;
              best_avg_r <= ram_rdata.avg;
              best_w_r   <= cur_w;
            end
          end
          if (state_nxt == S_RD && strat_r == ST_RR) rr_r <= rr_r + 32'd1;
        end
      end

      if (state_r == S_UPD) begin
        case (func_t'(func_r))
          FN_ADD: if (slot_ok) begin
            present_r[s_idx] <= 1'b1;
            healthy_r[s_idx] <= flag_r;
          end
          FN_HEALTH: if (here) healthy_r[s_idx] <= flag_r;
          FN_REMOVE: if (here) begin
            present_r[s_idx] <= 1'b0;
            healthy_r[s_idx] <= 1'b0;
          end
          default: ;
        endcase
      end

      if (state_r == S_OUT) ov_r <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      o_cv_r   <= 1'b0;
      o_slot_r <= slot_r;
      o_sts_r  <= STS_ABSENT;
      o_act_r  <= '0;
      case (func_t'(func_r))
        FN_SELECT: begin
          o_cv_r   <= 1'b1;
          o_slot_r <= 4'(best_r);
          o_sts_r  <= STS_OK;
          o_act_r  <= upd.active;
        end
        FN_ADD: if (slot_ok) o_sts_r <= STS_OK;
        FN_SUCCESS, FN_FAILURE: if (here) begin
          o_sts_r <= STS_OK;
          o_act_r <= upd.active;
        end
        FN_HEALTH: if (here) begin
          o_sts_r <= STS_OK;
          o_act_r <= ram_rdata.active;
        end
        FN_REMOVE: if (here) o_sts_r <= STS_OK;
        default: ;
      endcase
    end else if (state_r == S_SCAN && state_nxt == S_OUT) begin
      o_cv_r   <= 1'b0;
      o_slot_r <= '0;
      o_sts_r  <= STS_NONE;
      o_act_r  <= '0;
    end
  end

  assign out_valid        = ov_r;
  assign out_chosen_valid = o_cv_r;
  assign out_chosen_slot  = o_slot_r;
  assign out_status       = o_sts_r;
  assign out_active_count = o_act_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_ok_select: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_cv_r) |-> (o_sts_r == STS_OK)) else $error("bad select result");
  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !ram_we) else $error("write during scan");
endmodule
